// File: src/lctp_pkg.sv
package lctp_pkg;

    // Default line length limit in kept bytes.
    localparam int LINE_CHARS_DEFAULT = 63;

    // Depth of the command queue between the parser and the threshold unit.
    localparam int QUEUE_DEPTH = 2;

    // Command kinds reported on command_kind.
    localparam logic [2:0] KIND_TEMP    = 3'd0;
    localparam logic [2:0] KIND_CO2     = 3'd1;
    localparam logic [2:0] KIND_TVOC    = 3'd2;
    localparam logic [2:0] KIND_ALARM   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // ASCII codes the parser cares about.
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // One decoded command as it travels from the parser to the threshold unit.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
    } cmd_t;

    // Fill status of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: src/lctp_front.sv
module lctp_front #(
    parameter int LINE_CHARS = lctp_pkg::LINE_CHARS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  lctp_pkg::queue_status_t q_status,
    output logic                push,
    output lctp_pkg::cmd_t      push_cmd
);
    import lctp_pkg::*;

    localparam int CntW = $clog2(LINE_CHARS + 1);
    localparam logic [CntW-1:0] CntLimit = CntW'(LINE_CHARS);

    typedef enum logic [2:0] {
        PH_WS1, PH_SG1, PH_D1, PH_WS2, PH_SG2, PH_D2, PH_DONE, PH_FAIL
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [7:0]      id_reg, id_next;
    logic            id_neg_reg, id_neg_next;
    logic [15:0]     val_reg, val_next;
    logic            val_neg_reg, val_neg_next;

    logic            is_ws, is_digit, is_sign, is_minus, is_eol;
    logic [3:0]      digit;
    logic [11:0]     id_wide;
    logic [7:0]      id_sat;
    logic [15:0]     val_acc;
    logic            accept;

    // Byte classification.
    assign is_ws    = (rx_byte == CHAR_SPACE) || (rx_byte == CHAR_TAB) ||
                      (rx_byte == CHAR_VT) || (rx_byte == CHAR_FF);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_minus = (rx_byte == CHAR_MINUS);
    assign is_sign  = (rx_byte == CHAR_PLUS) || is_minus;
    assign is_eol   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign digit    = rx_byte[3:0];

    // Times-ten accumulate as shifts and adds; the identifier saturates.
    assign id_wide = {1'b0, id_reg, 3'b000} + {3'b000, id_reg, 1'b0} + {8'h00, digit};
    assign id_sat  = (id_wide > 12'd255) ? 8'hFF : id_wide[7:0];
    assign val_acc = {val_reg[12:0], 3'b000} + {val_reg[14:0], 1'b0} + {12'h000, digit};

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    // Command formed from the line state at a line end.
    always_comb
    begin
        push_cmd.value = val_neg_reg ? ((~val_reg) + 16'd1) : val_reg;
        if (id_neg_reg)
        begin
            push_cmd.kind = KIND_UNKNOWN;
        end
        else
        begin
            unique case (id_reg)
                8'd1:    push_cmd.kind = KIND_TEMP;
                8'd2:    push_cmd.kind = KIND_CO2;
                8'd3:    push_cmd.kind = KIND_TVOC;
                8'd4:    push_cmd.kind = KIND_ALARM;
                default: push_cmd.kind = KIND_UNKNOWN;
            endcase
        end
    end

    // Streaming matcher for two signed decimal numbers.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        id_next      = id_reg;
        id_neg_next  = id_neg_reg;
        val_next     = val_reg;
        val_neg_next = val_neg_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (is_eol)
            begin
                if (count_reg != '0)
                begin
                    push         = (phase_reg == PH_D2) || (phase_reg == PH_DONE);
                    phase_next   = PH_WS1;
                    count_next   = '0;
                    id_next      = '0;
                    id_neg_next  = 1'b0;
                    val_next     = '0;
                    val_neg_next = 1'b0;
                end
            end
            else if (count_reg < CntLimit)
            begin
                count_next = count_reg + 1'b1;
                unique case (phase_reg)
                    PH_WS1:
                    begin
                        priority if (is_ws)
                        begin
                        end
                        else if (is_sign)
                        begin
                            id_neg_next = is_minus;
                            phase_next  = PH_SG1;
                        end
                        else if (is_digit)
                        begin
                            id_next    = id_sat;
                            phase_next = PH_D1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_SG1:
                    begin
                        if (is_digit)
                        begin
                            id_next    = id_sat;
                            phase_next = PH_D1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_D1:
                    begin
                        priority if (is_digit)
                        begin
                            id_next = id_sat;
                        end
                        else if (is_ws)
                        begin
                            phase_next = PH_WS2;
                        end
                        else if (is_sign)
                        begin
                            val_neg_next = is_minus;
                            phase_next   = PH_SG2;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_WS2:
                    begin
                        priority if (is_ws)
                        begin
                        end
                        else if (is_sign)
                        begin
                            val_neg_next = is_minus;
                            phase_next   = PH_SG2;
                        end
                        else if (is_digit)
                        begin
                            val_next   = val_acc;
                            phase_next = PH_D2;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_SG2:
                    begin
                        if (is_digit)
                        begin
                            val_next   = val_acc;
                            phase_next = PH_D2;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_D2:
                    begin
                        if (is_digit)
                        begin
                            val_next = val_acc;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE, PH_FAIL:
                    begin
                    end
                endcase
            end
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WS1;
            count_reg   <= '0;
            id_reg      <= '0;
            id_neg_reg  <= 1'b0;
            val_reg     <= '0;
            val_neg_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            id_reg      <= id_next;
            id_neg_reg  <= id_neg_next;
            val_reg     <= val_next;
            val_neg_reg <= val_neg_next;
        end
    end

endmodule

// File: src/lctp_queue.sv
module lctp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lctp_pkg::cmd_t          push_cmd,
    input  logic                    pop,
    output lctp_pkg::cmd_t          head_cmd,
    output lctp_pkg::queue_status_t status
);
    import lctp_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

    cmd_t            mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == CntFull);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/lctp_back.sv
module lctp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lctp_pkg::queue_status_t q_status,
    input  lctp_pkg::cmd_t          head_cmd,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              command_kind,
    output logic [15:0]             command_value,
    output logic [15:0]             temp_limit,
    output logic [15:0]             co2_limit,
    output logic [15:0]             tvoc_limit,
    output logic                    remote_alarm
);
    import lctp_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg;
    logic [15:0] value_reg;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] co2_reg, co2_next;
    logic [15:0] tvoc_reg, tvoc_next;
    logic        alarm_reg, alarm_next;

    // Take a command whenever the output register is free or being emptied.
    assign pop = !q_status.empty && (!valid_reg || out_ready);

    // Threshold updates.
    always_comb
    begin
        temp_next  = temp_reg;
        co2_next   = co2_reg;
        tvoc_next  = tvoc_reg;
        alarm_next = alarm_reg;
        valid_next = valid_reg && !out_ready;
        if (pop)
        begin
            valid_next = 1'b1;
            unique case (head_cmd.kind)
                KIND_TEMP:  temp_next  = head_cmd.value;
                KIND_CO2:   co2_next   = head_cmd.value;
                KIND_TVOC:  tvoc_next  = head_cmd.value;
                KIND_ALARM: alarm_next = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // Threshold store and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            temp_reg  <= '0;
            co2_reg   <= '0;
            tvoc_reg  <= '0;
            alarm_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            temp_reg  <= temp_next;
            co2_reg   <= co2_next;
            tvoc_reg  <= tvoc_next;
            alarm_reg <= alarm_next;
        end
    end

    // Result payload; the thresholds are shown from the store itself.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head_cmd.kind;
            value_reg <= head_cmd.value;
        end
    end

    assign out_valid     = valid_reg;
    assign command_kind  = kind_reg;
    assign command_value = value_reg;
    assign temp_limit    = temp_reg;
    assign co2_limit     = co2_reg;
    assign tvoc_limit    = tvoc_reg;
    assign remote_alarm  = alarm_reg;

endmodule

// File: src/line_command_threshold_parser.sv
// Line command parser for alarm thresholds.
// Input channel: in_valid / in_ready with rx_byte, one received ASCII byte per
// item. Each line of the form "<id> <value>" ended by CR or LF yields one result
// item on out_valid / out_ready: command_kind, command_value and the current
// temperature, CO2 and TVOC thresholds plus the remote alarm flag after it.
// Lines that do not match, and empty lines, give no result.
// Throughput: one byte per cycle while the queue is not full. The parser
// updates its line state in the same cycle as the byte is taken (one
// times-ten accumulate per byte). When the line-ending byte is accepted, the
// command is written into the two-entry queue; it moves from there into the
// output register once that register is free or being emptied.
// When the receiver stalls, the output register holds its item and the queue
// absorbs up to two more commands; in_ready drops only while the queue is full.
// Reset clears the line state, all thresholds and the alarm flag to zero, and
// the block is ready for bytes as soon as reset is released.
module line_command_threshold_parser #(
    parameter int LINE_CHARS = lctp_pkg::LINE_CHARS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  command_kind,
    output logic [15:0] command_value,
    output logic [15:0] temp_limit,
    output logic [15:0] co2_limit,
    output logic [15:0] tvoc_limit,
    output logic        remote_alarm
);
    import lctp_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    cmd_t          push_cmd;
    cmd_t          head_cmd;

    // Front: byte parser.
    lctp_front #(
        .LINE_CHARS(LINE_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between the two sides.
    lctp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back: threshold store and result register.
    lctp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command_kind  (command_kind),
        .command_value (command_value),
        .temp_limit    (temp_limit),
        .co2_limit     (co2_limit),
        .tvoc_limit    (tvoc_limit),
        .remote_alarm  (remote_alarm)
    );

endmodule

// File: src/lctp_checker.sv
module lctp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  command_kind,
    input logic [15:0] command_value,
    input logic [15:0] temp_limit,
    input logic [15:0] co2_limit,
    input logic        remote_alarm
);
    import lctp_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_value)
            && $stable(command_kind))
        else $error("result changed while stalled");

    // The reported kind is always a defined code.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_kind == KIND_TEMP) || (command_kind == KIND_CO2) ||
            (command_kind == KIND_TVOC) || (command_kind == KIND_ALARM) ||
            (command_kind == KIND_UNKNOWN))
        else $error("undefined command kind");

    // A temperature or CO2 threshold command is already reflected in the reported threshold.
    a_thresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((command_kind == KIND_TEMP && temp_limit != command_value) ||
            (command_kind == KIND_CO2 && co2_limit != command_value)) |-> 1'b0)
        else $error("threshold does not match command value");

    // An alarm command shows the alarm flag set.
    a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_kind == KIND_ALARM |-> remote_alarm)
        else $error("alarm command without alarm flag");

endmodule

bind line_command_threshold_parser lctp_checker u_lctp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_kind  (command_kind),
    .command_value (command_value),
    .temp_limit    (temp_limit),
    .co2_limit     (co2_limit),
    .remote_alarm  (remote_alarm)
);

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lctp_pkg::*;

    // One command result as seen on the output channel.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [15:0] temp;
        logic [15:0] co2;
        logic [15:0] tvoc;
        logic        alarm;
    } cmd_result_t;

    // Where the "%d %d" scan of the current line stands.
    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_ID_SIGN,
        SCAN_ID,
        SCAN_GAP,
        SCAN_VAL_SIGN,
        SCAN_VAL,
        SCAN_DONE,
        SCAN_FAIL
    } scan_e;

    // Tracks the parser state byte by byte and holds the commands still due.
    class cmd_line_tracker;
        scan_e       scan;
        int          kept;
        logic [7:0]  id_mag;
        logic        id_neg;
        logic [15:0] val_mag;
        logic        val_neg;
        logic [15:0] temp;
        logic [15:0] co2;
        logic [15:0] tvoc;
        logic        alarm;
        cmd_result_t pending_cmds[$];
        int          mismatches;

        function new();
            clear_line();
            temp = '0;
            co2 = '0;
            tvoc = '0;
            alarm = 1'b0;
            mismatches = 0;
        endfunction

        function void clear_line();
            scan = SCAN_LEAD;
            kept = 0;
            id_mag = '0;
            id_neg = 1'b0;
            val_mag = '0;
            val_neg = 1'b0;
        endfunction

        static function bit is_space(logic [7:0] c);
            return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF;
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function void add_id_digit(logic [7:0] c);
            int v;
            v = int'(id_mag) * 10 + int'(c - CHAR_ZERO);
            id_mag = (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function void add_val_digit(logic [7:0] c);
            int v;
            v = int'(val_mag) * 10 + int'(c - CHAR_ZERO);
            val_mag = v[15:0];
        endfunction

        // Advance the scanner by one kept byte.
        function void scan_byte(logic [7:0] c);
            bit sign;
            sign = (c == CHAR_PLUS || c == CHAR_MINUS);
            case (scan)
                SCAN_LEAD:
                begin
                    if (is_space(c)) begin
                    end else if (sign) begin
                        id_neg = (c == CHAR_MINUS);
                        scan = SCAN_ID_SIGN;
                    end else if (is_digit(c)) begin
                        add_id_digit(c);
                        scan = SCAN_ID;
                    end else begin
                        scan = SCAN_FAIL;
                    end
                end
                SCAN_ID_SIGN:
                begin
                    if (is_digit(c)) begin
                        add_id_digit(c);
                        scan = SCAN_ID;
                    end else begin
                        scan = SCAN_FAIL;
                    end
                end
                SCAN_ID:
                begin
                    if (is_digit(c)) begin
                        add_id_digit(c);
                    end else if (is_space(c)) begin
                        scan = SCAN_GAP;
                    end else if (sign) begin
                        val_neg = (c == CHAR_MINUS);
                        scan = SCAN_VAL_SIGN;
                    end else begin
                        scan = SCAN_FAIL;
                    end
                end
                SCAN_GAP:
                begin
                    if (is_space(c)) begin
                    end else if (sign) begin
                        val_neg = (c == CHAR_MINUS);
                        scan = SCAN_VAL_SIGN;
                    end else if (is_digit(c)) begin
                        add_val_digit(c);
                        scan = SCAN_VAL;
                    end else begin
                        scan = SCAN_FAIL;
                    end
                end
                SCAN_VAL_SIGN:
                begin
                    if (is_digit(c)) begin
                        add_val_digit(c);
                        scan = SCAN_VAL;
                    end else begin
                        scan = SCAN_FAIL;
                    end
                end
                SCAN_VAL:
                begin
                    if (is_digit(c)) begin
                        add_val_digit(c);
                    end else begin
                        scan = SCAN_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Note one accepted byte; a completed line may queue one command.
        function void take_byte(logic [7:0] c);
            cmd_result_t cmd;
            bit matched;
            if (c != CHAR_LF && c != CHAR_CR) begin
                if (kept < LINE_CHARS_DEFAULT) begin
                    kept++;
                    scan_byte(c);
                end
                return;
            end
            // An empty line is ignored altogether.
            if (kept == 0) begin
                return;
            end
            matched = (scan == SCAN_VAL || scan == SCAN_DONE);
            cmd.value = val_neg ? 16'(-val_mag) : val_mag;
            cmd.kind = KIND_UNKNOWN;
            if (!id_neg) begin
                case (id_mag)
                    8'd1: cmd.kind = KIND_TEMP;
                    8'd2: cmd.kind = KIND_CO2;
                    8'd3: cmd.kind = KIND_TVOC;
                    8'd4: cmd.kind = KIND_ALARM;
                    default: cmd.kind = KIND_UNKNOWN;
                endcase
            end
            clear_line();
            if (!matched) begin
                return;
            end
            case (cmd.kind)
                KIND_TEMP: temp = cmd.value;
                KIND_CO2: co2 = cmd.value;
                KIND_TVOC: tvoc = cmd.value;
                KIND_ALARM: alarm = 1'b1;
                default:
                begin
                end
            endcase
            cmd.temp = temp;
            cmd.co2 = co2;
            cmd.tvoc = tvoc;
            cmd.alarm = alarm;
            pending_cmds.push_back(cmd);
        endfunction

        function void report(string what, cmd_result_t exp, cmd_result_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] %s", $realtime, what);
                $display("    expected kind=%0d value=%h temp=%h co2=%h tvoc=%h alarm=%b",
                         exp.kind, exp.value, exp.temp, exp.co2, exp.tvoc, exp.alarm);
                $display("    actual   kind=%0d value=%h temp=%h co2=%h tvoc=%h alarm=%b",
                         got.kind, got.value, got.temp, got.co2, got.tvoc, got.alarm);
            end
        endfunction

        // Compare one output item with the oldest command due.
        function void match_command(cmd_result_t got);
            cmd_result_t exp;
            if (pending_cmds.size() == 0) begin
                exp = 'x;
                report("command item with none due", exp, got);
                return;
            end
            exp = pending_cmds.pop_front();
            if (got.kind !== exp.kind || got.value !== exp.value || got.temp !== exp.temp
                || got.co2 !== exp.co2 || got.tvoc !== exp.tvoc || got.alarm !== exp.alarm) begin
                report("command item mismatch", exp, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  command_kind;
    logic [15:0] command_value;
    logic [15:0] temp_limit;
    logic [15:0] co2_limit;
    logic [15:0] tvoc_limit;
    logic        remote_alarm;

    cmd_line_tracker tracker;
    int              bytes_sent;
    bit              sender_calm;

    line_command_threshold_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command_kind  (command_kind),
        .command_value (command_value),
        .temp_limit    (temp_limit),
        .co2_limit     (co2_limit),
        .tvoc_limit    (tvoc_limit),
        .remote_alarm  (remote_alarm)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            default: return CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_line_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CHAR_LF || c == CHAR_CR);
        return c;
    endfunction

    // Offer one byte and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // Build one random line, mostly well formed, and send it.
    task automatic send_random_line();
        logic [7:0] q[$];
        int         mode;
        int         r;
        mode = $urandom_range(0, 99);
        sender_calm = ($urandom_range(0, 4) == 0);
        if (mode < 12) begin
            repeat ($urandom_range(1, 12)) q.push_back(pick_line_byte());
        end else begin
            // Lead-in; a long one can push the numbers past the line limit.
            if (mode >= 95) begin
                repeat ($urandom_range(40, 70)) q.push_back(pick_space());
            end else begin
                repeat ($urandom_range(0, 2)) q.push_back(pick_space());
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                q.push_back(CHAR_MINUS);
            end else if (r < 22) begin
                q.push_back(CHAR_PLUS);
            end
            if ($urandom_range(0, 99) < 75) begin
                q.push_back(CHAR_ZERO + 8'($urandom_range(1, 4)));
            end else begin
                repeat ($urandom_range(1, 4)) q.push_back(pick_digit());
            end
            if ($urandom_range(0, 99) < 75) begin
                repeat ($urandom_range(1, 3)) q.push_back(pick_space());
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
                q.push_back(CHAR_MINUS);
            end else if (r < 35) begin
                q.push_back(CHAR_PLUS);
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(6, 9)) q.push_back(pick_digit());
            end else begin
                repeat ($urandom_range(1, 5)) q.push_back(pick_digit());
            end
            // Broken lines: one stray byte, NUL often, somewhere inside.
            if (mode < 22) begin
                q.insert($urandom_range(0, q.size() - 1),
                         ($urandom_range(0, 1) == 0) ? 8'h00 : pick_line_byte());
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) q.push_back(pick_line_byte());
            end
        end
        q.push_back(($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR);
        if ($urandom_range(0, 99) < 15) begin
            q.push_back(($urandom_range(0, 1) == 0) ? CHAR_LF : CHAR_CR);
        end
        foreach (q[i]) begin
            send_byte(q[i]);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        tracker = new();
        bytes_sent = 0;
        sender_calm = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: every kind, signs, wrap, saturation, empty and failed lines.
        // The octal escape 015 is a carriage return.
        send_text("4 0\n\015");
        send_text("-1+65535\015");
        send_text("\t3 -70000\n");
        send_text("2 12");
        send_byte(8'h00);
        send_text("9\n");
        send_text("1");
        send_byte(8'h00);
        send_text(" 5\n+ 5\n300 7\n1 -1\n");

        while (bytes_sent < 1650) begin
            send_random_line();
        end
        in_valid <= 1'b0;

        while (tracker.pending_cmds.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_cmds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: random stalls, calm stretches, and one long hold-off to fill the block.
    initial
    begin
        int          stall_left;
        int          cycle;
        int          r;
        bit          held;
        cmd_result_t got;
        stall_left = 0;
        cycle = 0;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (out_valid && out_ready) begin
                got.kind = command_kind;
                got.value = command_value;
                got.temp = temp_limit;
                got.co2 = co2_limit;
                got.tvoc = tvoc_limit;
                got.alarm = remote_alarm;
                tracker.match_command(got);
            end
            if (!held && bytes_sent >= 300) begin
                held = 1'b1;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if ((cycle / 256) % 4 == 1 || r < 70) begin
                    out_ready <= 1'b1;
                end else begin
                    out_ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
